[src/ffha_pkg.sv]
// shared types, constants and codes of the first-fit heap allocator
// depends on nothing; used by every module of the block
package ffha_pkg;

	localparam int OFS_W  = 15;
	localparam int SIZE_W = 16;

	localparam int ARENA_BYTES_DEF  = 32768;
	localparam int HEADER_BYTES_DEF = 24;
	localparam int MAX_BLOCKS_DEF   = 64;

	typedef enum logic [2:0] {
		STAT_ALLOCATED = 3'd0,
		STAT_NO_FIT    = 3'd1,
		STAT_RELEASED  = 3'd2,
		STAT_NULL      = 3'd3,
		STAT_UNKNOWN   = 3'd4,
		STAT_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] request_bytes;
		logic [OFS_W-1:0]  payload_offset;
	} req_beat_t;

	typedef struct packed {
		status_t          status;
		logic [OFS_W-1:0] granted_offset;
	} rsp_beat_t;

	typedef struct packed {
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] len;
		logic             free;
	} rec_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN_RD,
		CMD_SCAN_EV,
		CMD_UP_RD,
		CMD_UP_WR,
		CMD_SPLIT_NEW,
		CMD_SPLIT_OWN,
		CMD_MRG_START,
		CMD_MRG_LD0,
		CMD_MRG_RD1,
		CMD_MRG_EV,
		CMD_MSH_RD,
		CMD_MSH_WR,
		CMD_FINISH
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_UP_RD,
		S_UP_WR,
		S_SPLIT_NEW,
		S_SPLIT_OWN,
		S_MRG_START,
		S_MRG_LD0,
		S_MRG_RD1,
		S_MRG_EV,
		S_MSH_RD,
		S_MSH_WR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic req_null;
		logic is_release;
		logic hit;
		logic split;
		logic full;
		logic idx_last;
		logic j_at_gap;
		logic j_last;
		logic both_free;
		logic out_busy;
	} flags_t;

endpackage

[src/ffha_ctrl.sv]
// sequencer of the allocator: scan, insertion shift, merge pass
// depends on ffha_pkg; drives ffha_dp through a command code
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ffha_pkg::flags_t flags,
	output ffha_pkg::cmd_t  cmd
);
	import ffha_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = CMD_NONE;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd      = CMD_LOAD;
					state_nx = flags.req_null ? S_FINISH : S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd      = CMD_SCAN_RD;
				state_nx = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd = CMD_SCAN_EV;
				if (!flags.hit) begin
					state_nx = flags.idx_last ? S_FINISH : S_SCAN_RD;
				end else if (flags.is_release) begin
					state_nx = S_MRG_START;
				end else if (flags.split && !flags.full) begin
					state_nx = S_UP_RD;
				end else begin
					state_nx = S_FINISH;
				end
			end
			S_UP_RD: begin
				cmd      = CMD_UP_RD;
				state_nx = flags.j_at_gap ? S_SPLIT_NEW : S_UP_WR;
			end
			S_UP_WR: begin
				cmd      = CMD_UP_WR;
				state_nx = S_UP_RD;
			end
			S_SPLIT_NEW: begin
				cmd      = CMD_SPLIT_NEW;
				state_nx = S_SPLIT_OWN;
			end
			S_SPLIT_OWN: begin
				cmd      = CMD_SPLIT_OWN;
				state_nx = S_FINISH;
			end
			S_MRG_START: begin
				cmd      = CMD_MRG_START;
				state_nx = flags.idx_last ? S_FINISH : S_MRG_LD0;
			end
			S_MRG_LD0: begin
				cmd      = CMD_MRG_LD0;
				state_nx = S_MRG_RD1;
			end
			S_MRG_RD1: begin
				cmd      = CMD_MRG_RD1;
				state_nx = flags.idx_last ? S_FINISH : S_MRG_EV;
			end
			S_MRG_EV: begin
				cmd      = CMD_MRG_EV;
				state_nx = flags.both_free ? S_MSH_RD : S_MRG_RD1;
			end
			S_MSH_RD: begin
				cmd      = CMD_MSH_RD;
				state_nx = flags.j_last ? S_MRG_RD1 : S_MSH_WR;
			end
			S_MSH_WR: begin
				cmd      = CMD_MSH_WR;
				state_nx = S_MSH_RD;
			end
			S_FINISH: begin
				cmd = CMD_FINISH;
				if (!flags.out_busy) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

[src/ffha_dp.sv]
// datapath of the allocator: record memory, indexes, compares, result register
// depends on ffha_pkg; commanded by ffha_ctrl
module ffha_dp #(
	parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::req_beat_t req,
	input  ffha_pkg::cmd_t      cmd,
	output ffha_pkg::flags_t    flags,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ffha_pkg::rsp_beat_t rsp
);
	import ffha_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [SIZE_W:0] HDR = (SIZE_W + 1)'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);
	localparam rec_t RESET_REC = '{
		start: '0,
		len:   OFS_W'(ARENA_BYTES - HEADER_BYTES),
		free:  1'b1
	};

	rec_t             mem [MAX_BLOCKS];
	rec_t             mem_rd_q;
	logic             rd_zero_q;
	logic             w0_q;
	rec_t             rd;

	req_beat_t        req_q;
	rec_t             cur_q;
	logic [CNT_W-1:0] idx_q, j_q, count_q;
	rsp_beat_t        res_q;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	rec_t             wr_data;

	logic [CNT_W:0]   idx_p1;
	logic [SIZE_W:0]  need;
	logic [SIZE_W:0]  start_h;
	logic [OFS_W-1:0] merged_len;
	logic [OFS_W-1:0] granted;

	assign rd      = rd_zero_q ? RESET_REC : mem_rd_q;
	assign idx_p1  = {1'b0, idx_q} + 1'b1;
	assign need    = {1'b0, req_q.request_bytes} + HDR;
	assign start_h = (SIZE_W + 1)'(rd.start) + HDR;
	assign granted = OFS_W'(cur_q.start + OFS_W'(HEADER_BYTES));
	assign merged_len = OFS_W'(cur_q.len + OFS_W'(HEADER_BYTES) + rd.len);

	// status toward the sequencer
	always_comb begin
		flags.req_null   = req.mode && (req.payload_offset == '0);
		flags.is_release = req_q.mode;
		flags.hit        = req_q.mode
			? (start_h == (SIZE_W + 1)'(req_q.payload_offset))
			: (rd.free && ({1'b0, rd.len} >= req_q.request_bytes));
		flags.split      = (SIZE_W + 1)'(rd.len) > need;
		flags.full       = count_q >= MAXC;
		flags.idx_last   = idx_p1 >= {1'b0, count_q};
		flags.j_at_gap   = {1'b0, j_q} == idx_p1;
		flags.j_last     = ({1'b0, j_q} + 1'b1) >= {1'b0, count_q};
		flags.both_free  = cur_q.free && rd.free;
		flags.out_busy   = rsp_valid_q && rsp_stall;
	end

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd;
		case (cmd)
			CMD_SCAN_RD, CMD_MRG_START: begin
				rd_en = 1'b1;
			end
			CMD_SCAN_EV: begin
				if (flags.hit) begin
					if (req_q.mode) begin
						wr_en   = 1'b1;
						wr_data = '{start: rd.start, len: rd.len, free: 1'b1};
					end else if (!flags.split) begin
						wr_en   = 1'b1;
						wr_data = '{start: rd.start,
							len: OFS_W'(req_q.request_bytes), free: 1'b0};
					end
				end
			end
			CMD_UP_RD: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(j_q - 1'b1);
			end
			CMD_UP_WR, CMD_MSH_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IDX_W-1:0];
			end
			CMD_SPLIT_NEW: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(idx_p1);
				wr_data = '{
					start: OFS_W'(cur_q.start + OFS_W'(HEADER_BYTES)
						+ OFS_W'(req_q.request_bytes)),
					len:   OFS_W'(cur_q.len - OFS_W'(req_q.request_bytes)
						- OFS_W'(HEADER_BYTES)),
					free:  1'b1};
			end
			CMD_SPLIT_OWN: begin
				wr_en   = 1'b1;
				wr_data = '{start: cur_q.start,
					len: OFS_W'(req_q.request_bytes), free: 1'b0};
			end
			CMD_MRG_RD1: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(idx_p1);
			end
			CMD_MRG_EV: begin
				if (flags.both_free) begin
					wr_en   = 1'b1;
					wr_data = '{start: cur_q.start, len: merged_len, free: 1'b1};
				end
			end
			CMD_MSH_RD: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(j_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// entry zero reads as its reset value until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q      <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0) begin
				w0_q <= 1'b1;
			end
			if (rd_en) begin
				rd_zero_q <= (rd_addr == '0) && !w0_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd == CMD_SPLIT_OWN) begin
				count_q <= count_q + 1'b1;
			end else if (cmd == CMD_MSH_RD && flags.j_last) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd == CMD_FINISH && !flags.out_busy) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				req_q <= req;
				idx_q <= '0;
				res_q.granted_offset <= '0;
				if (flags.req_null) begin
					res_q.status <= STAT_NULL;
				end else begin
					res_q.status <= req.mode ? STAT_UNKNOWN : STAT_NO_FIT;
				end
			end
			CMD_SCAN_EV: begin
				cur_q <= rd;
				if (!flags.hit) begin
					idx_q <= CNT_W'(idx_p1);
				end else if (req_q.mode) begin
					res_q.status <= STAT_RELEASED;
					idx_q        <= '0;
				end else if (flags.split) begin
					if (flags.full) begin
						res_q.status <= STAT_FULL;
					end else begin
						j_q <= count_q;
					end
				end else begin
					res_q.status         <= STAT_ALLOCATED;
					res_q.granted_offset <= OFS_W'(start_h);
				end
			end
			CMD_UP_WR: begin
				j_q <= j_q - 1'b1;
			end
			CMD_SPLIT_OWN: begin
				res_q.status         <= STAT_ALLOCATED;
				res_q.granted_offset <= granted;
			end
			CMD_MRG_LD0: begin
				cur_q <= rd;
			end
			CMD_MRG_EV: begin
				if (flags.both_free) begin
					cur_q.len <= merged_len;
					j_q       <= CNT_W'(idx_p1);
				end else begin
					cur_q <= rd;
					idx_q <= CNT_W'(idx_p1);
				end
			end
			CMD_MSH_WR: begin
				j_q <= j_q + 1'b1;
			end
			CMD_FINISH: begin
				if (!flags.out_busy) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/first_fit_heap_allocator.sv]
// first-fit heap allocator: one request beat in, one result beat out
// work per request: each record scanned, plus each record shifted on a split or a merge,
// and each record visited by the merge pass; the longest case is a release that merges
// with both neighbors near the front; a null release goes straight to its result
// one request at a time, next beat accepted the cycle after the result is registered
// reset: asynchronous, table holds one free block of the arena minus a header; no clearing pass
module first_fit_heap_allocator #(
	parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request side
	input  logic                req_valid,
	output logic                req_stall,
	input  ffha_pkg::req_beat_t req,
	// result side, registered
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ffha_pkg::rsp_beat_t rsp
);
	import ffha_pkg::*;

	// command from the sequencer, status back from the datapath
	cmd_t   cmd;
	flags_t flags;

	// sequencer: idle accepts a beat, then scan / shift / merge, then finish
	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	// record memory, indexes and the result register
	ffha_dp #(
		.ARENA_BYTES  (ARENA_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.flags     (flags),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[src/ffha_checker.sv]
// port-level checks of the first-fit heap allocator
// depends on ffha_pkg; bound to first_fit_heap_allocator below
module ffha_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input ffha_pkg::req_beat_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input ffha_pkg::rsp_beat_t rsp
);
	import ffha_pkg::*;

	// one request in flight: stall rises right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

	// a result beat never appears in the cycle after an accept, unless an earlier one is held by a stall
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !(rsp_valid && rsp_stall) |=> !rsp_valid)
		else $error("result without work");

	// only an allocation carries an offset
	a_offset_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_ALLOCATED |-> rsp.granted_offset == '0)
		else $error("offset on a non-grant");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
